[src/xagd_pkg.sv]
// Package with the coefficient and range tables of the ADPCM group decoder.
package xagd_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned ACC_W    = 26;

    typedef enum logic
    {
        OP_HEADER = 1'b0,
        OP_DATA   = 1'b1
    } op_t;

    // First predictor coefficient, x64.
    function automatic logic signed [7:0] k0_x64(input logic [2:0] sel);
        logic signed [7:0] k;
        unique case (sel)
            3'd0:    k = 8'sd0;
            3'd1:    k = 8'sd60;
            3'd2:    k = 8'sd115;
            3'd3:    k = 8'sd98;
            3'd4:    k = 8'sd122;
            3'd5:    k = 8'sd115;
            3'd6:    k = 8'sd115;
            3'd7:    k = 8'sd60;
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

    // Second predictor coefficient, x64.
    function automatic logic signed [6:0] k1_x64(input logic [2:0] sel);
        logic signed [6:0] k;
        unique case (sel)
            3'd0:    k = 7'sd0;
            3'd1:    k = 7'sd0;
            3'd2:    k = -7'sd52;
            3'd3:    k = -7'sd55;
            3'd4:    k = -7'sd60;
            3'd5:    k = -7'sd60;
            3'd6:    k = -7'sd55;
            3'd7:    k = -7'sd26;
            default: k = 7'sd0;
        endcase
        return k;
    endfunction

    // Nibble step size, x16.
    function automatic logic [16:0] range_x16(input logic [4:0] sel);
        logic [16:0] r;
        unique case (sel)
            5'd0:    r = 17'd16;
            5'd1:    r = 17'd21;
            5'd2:    r = 17'd27;
            5'd3:    r = 17'd36;
            5'd4:    r = 17'd47;
            5'd5:    r = 17'd61;
            5'd6:    r = 17'd80;
            5'd7:    r = 17'd105;
            5'd8:    r = 17'd137;
            5'd9:    r = 17'd179;
            5'd10:   r = 17'd234;
            5'd11:   r = 17'd306;
            5'd12:   r = 17'd400;
            5'd13:   r = 17'd524;
            5'd14:   r = 17'd685;
            5'd15:   r = 17'd895;
            5'd16:   r = 17'd1171;
            5'd17:   r = 17'd1531;
            5'd18:   r = 17'd2003;
            5'd19:   r = 17'd2619;
            5'd20:   r = 17'd3425;
            5'd21:   r = 17'd4479;
            5'd22:   r = 17'd5858;
            5'd23:   r = 17'd7661;
            5'd24:   r = 17'd10018;
            5'd25:   r = 17'd13101;
            5'd26:   r = 17'd17133;
            5'd27:   r = 17'd22406;
            5'd28:   r = 17'd29302;
            5'd29:   r = 17'd38320;
            5'd30:   r = 17'd50113;
            5'd31:   r = 17'd65536;
            default: r = 17'd16;
        endcase
        return r;
    endfunction

endpackage

[src/xa_style_adpcm_group_decoder.sv]
// Top level: ADPCM group decoder, one sample per cycle from a held input item
// while the result is not stalled. Each item is decoded one sample per step,
// and the next item is taken in the step that decodes its second sample, so a
// new item is accepted before the last is through. A stalled result holds the
// decoder and the input, save on the silent final byte of a group. Reset is
// asynchronous, active low, and clears history, selects, byte count and valids.
module xa_style_adpcm_group_decoder
    import xagd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       op,
    input  logic [31:0]                header_word,
    input  logic [7:0]                 data_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       last
);

    // held item
    logic                       w_valid_reg;
    logic                       w_phase_reg;
    op_t                        w_op_reg;
    logic [31:0]                w_hdr_reg;
    logic [7:0]                 w_byte_reg;

    // decoder state
    logic signed [SAMPLE_W-1:0] h1_reg;
    logic signed [SAMPLE_W-1:0] h2_reg;
    logic [2:0]                 coef_reg;
    logic [4:0]                 scale_reg;
    logic [4:0]                 idx_reg;

    // result register
    logic                       o_valid_reg;
    logic signed [SAMPLE_W-1:0] o_sample_reg;
    logic                       o_last_reg;

    logic                       out_free;
    logic                       silent;
    logic                       advance;
    logic                       in_take;

    logic signed [3:0]          nib;
    logic signed [17:0]         rng_s;
    logic signed [21:0]         p_n;
    logic signed [23:0]         p1;
    logic signed [22:0]         p2;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    adj;
    logic signed [19:0]         quo;
    logic signed [SAMPLE_W-1:0] dec;
    logic signed [SAMPLE_W-1:0] hdr_h2;
    logic signed [SAMPLE_W-1:0] hdr_h1;
    logic signed [SAMPLE_W-1:0] step_sample;

    assign hdr_h2 = $signed({w_hdr_reg[31:20], 4'b0000});
    assign hdr_h1 = $signed({w_hdr_reg[19:8], 4'b0000});

    // nibble decode: n*range*4 + h1*k0 + h2*k1, then /64 toward zero, clamp
    assign nib   = w_phase_reg ? $signed(w_byte_reg[3:0]) : $signed(w_byte_reg[7:4]);
    assign rng_s = $signed({1'b0, range_x16(scale_reg)});
    assign p_n   = 22'(nib) * 22'(rng_s);
    assign p1    = 24'(h1_reg) * 24'(k0_x64(coef_reg));
    assign p2    = 23'(h2_reg) * 23'(k1_x64(coef_reg));
    assign acc   = $signed({{2{p_n[21]}}, p_n, 2'b00})
                 + $signed({{2{p1[23]}}, p1})
                 + $signed({{3{p2[22]}}, p2});
    assign adj   = acc[ACC_W-1] ? acc + ACC_W'(63) : acc;
    assign quo   = adj[ACC_W-1:6];

    always_comb
    begin
        if (quo > 20'sd32767)
        begin
            dec = 16'sh7fff;
        end
        else if (quo < -20'sd32768)
        begin
            dec = -16'sh8000;
        end
        else
        begin
            dec = quo[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        if (w_op_reg == OP_HEADER)
        begin
            step_sample = w_phase_reg ? h1_reg : hdr_h2;
        end
        else
        begin
            step_sample = dec;
        end
    end

    assign out_free = !o_valid_reg || !out_stall;
    assign silent   = (w_op_reg == OP_DATA) && (idx_reg == 5'd31);
    assign advance  = w_valid_reg && (silent || out_free);
    assign in_stall = w_valid_reg && !(advance && w_phase_reg);
    assign in_take  = in_valid && !in_stall;

    // held item and phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            w_phase_reg <= 1'b0;
        end
        else if (in_take)
        begin
            w_valid_reg <= 1'b1;
            w_phase_reg <= 1'b0;
        end
        else if (advance)
        begin
            w_valid_reg <= !w_phase_reg;
            w_phase_reg <= !w_phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            w_op_reg   <= op_t'(op);
            w_hdr_reg  <= header_word;
            w_byte_reg <= data_byte;
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_reg    <= '0;
            h2_reg    <= '0;
            coef_reg  <= '0;
            scale_reg <= '0;
            idx_reg   <= '0;
        end
        else if (advance)
        begin
            if (w_op_reg == OP_HEADER)
            begin
                if (!w_phase_reg)
                begin
                    h2_reg    <= hdr_h2;
                    h1_reg    <= hdr_h1;
                    coef_reg  <= w_hdr_reg[7:5];
                    scale_reg <= w_hdr_reg[4:0];
                    idx_reg   <= '0;
                end
            end
            else
            begin
                h2_reg <= h1_reg;
                h1_reg <= dec;
                if (w_phase_reg)
                begin
                    idx_reg <= idx_reg + 5'd1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (advance && !silent)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !silent)
        begin
            o_sample_reg <= step_sample;
            o_last_reg   <= w_phase_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign sample    = o_sample_reg;
    assign last      = o_last_reg;

endmodule

[src/xagd_chk.sv]
// Port checker for the ADPCM group decoder and its bind.
module xagd_chk
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] sample,
    input logic               last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample) && $stable(last))
        else $error("stalled result changed");

    // an accepted item stalls the input behind it
    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted in back-to-back cycles");

    // second sample of an item follows the first at once
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && last)
        else $error("second sample of an item did not follow");

endmodule

bind xa_style_adpcm_group_decoder xagd_chk u_xagd_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .last      (last)
);

[tb/sv/xa_style_adpcm_group_decoder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the ADPCM group decoder: headers and data bytes against a predictor.
module xa_style_adpcm_group_decoder_tb;
    import xagd_pkg::*;

    localparam int TOTAL_ITEMS    = 1000;
    localparam int HOLD_CYCLES    = 150;
    // Longest correct stretch without a handshake comes from the receiver hold-off.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] pcm;
        logic                       tail;
    } pcm_rec_t;

    class pcm_scoreboard;
        int step_x16[32] = '{
               16,    21,    27,    36,    47,    61,    80,   105,
              137,   179,   234,   306,   400,   524,   685,   895,
             1171,  1531,  2003,  2619,  3425,  4479,  5858,  7661,
            10018, 13101, 17133, 22406, 29302, 38320, 50113, 65536
        };
        int gain_recent[8] = '{0, 60, 115, 98, 122, 115, 115, 60};
        int gain_older[8]  = '{0, 0, -52, -55, -60, -60, -55, -26};

        logic signed [15:0] hist_new;
        logic signed [15:0] hist_old;
        logic [2:0]         coef_sel;
        logic [4:0]         scale_sel;
        logic [4:0]         byte_cnt;
        pcm_rec_t           pcm_due[$];
        int                 fails;

        function new();
            hist_new  = '0;
            hist_old  = '0;
            coef_sel  = '0;
            scale_sel = '0;
            byte_cnt  = '0;
            fails     = 0;
        endfunction

        function logic signed [15:0] decode_nibble(logic [3:0] nib);
            longint acc;
            longint q;
            acc = longint'($signed(nib)) * step_x16[scale_sel] * 4
                + longint'(hist_new) * gain_recent[coef_sel]
                + longint'(hist_old) * gain_older[coef_sel];
            // signed division truncates toward zero
            q = acc / 64;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            hist_old = hist_new;
            hist_new = q[15:0];
            return q[15:0];
        endfunction

        function void note_item(op_t kind, logic [31:0] hw, logic [7:0] db);
            logic               silent;
            logic signed [15:0] s_hi;
            logic signed [15:0] s_lo;
            if (kind == OP_HEADER)
            begin
                hist_old  = {hw[31:20], 4'b0000};
                hist_new  = {hw[19:8], 4'b0000};
                coef_sel  = hw[7:5];
                scale_sel = hw[4:0];
                byte_cnt  = '0;
                pcm_due.push_back('{pcm: hist_old, tail: 1'b0});
                pcm_due.push_back('{pcm: hist_new, tail: 1'b1});
            end
            else
            begin
                // the 32nd byte of a group only advances the history
                silent   = (byte_cnt == 5'd31);
                s_hi     = decode_nibble(db[7:4]);
                s_lo     = decode_nibble(db[3:0]);
                byte_cnt = byte_cnt + 5'd1;
                if (!silent)
                begin
                    pcm_due.push_back('{pcm: s_hi, tail: 1'b0});
                    pcm_due.push_back('{pcm: s_lo, tail: 1'b1});
                end
            end
        endfunction

        function void check_sample(logic signed [15:0] got_pcm, logic got_tail);
            pcm_rec_t want;
            if (pcm_due.size() == 0)
            begin
                $error("unexpected sample %0d (last %0b)", got_pcm, got_tail);
                fails++;
                return;
            end
            want = pcm_due.pop_front();
            if (got_pcm !== want.pcm)
            begin
                $error("sample: expected %0d, actual %0d", want.pcm, got_pcm);
                fails++;
            end
            if (got_tail !== want.tail)
            begin
                $error("last: expected %0b, actual %0b", want.tail, got_tail);
                fails++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       op;
    logic [31:0]                header_word;
    logic [7:0]                 data_byte;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    pcm_scoreboard sb = new();
    bit            gaps_on   = 1'b1;
    bit            want_hold = 1'b0;
    int            items_sent = 0;
    int            quiet_cycles = 0;

    xa_style_adpcm_group_decoder DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .header_word (header_word),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample),
        .last        (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Handshakes are sampled with the values present just before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item(op_t'(op), header_word, data_byte);
            if (out_valid && !out_stall)
                sb.check_sample(sample, last);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (want_hold)
            begin
                want_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= gaps_on && ($urandom_range(0, 99) < 23);
        end
    end

    task automatic offer(op_t kind, logic [31:0] hw, logic [7:0] db);
        while (gaps_on && $urandom_range(0, 99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= kind;
        header_word <= hw;
        data_byte   <= db;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Hold the input quiet until every expected sample is out.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pcm_due.size() != 0);
    endtask

    function automatic logic [31:0] random_header();
        logic [31:0] hw;
        hw = $urandom;
        if ($urandom_range(0, 3) == 0)
            hw[4:0] = 5'($urandom_range(27, 31));
        if ($urandom_range(0, 9) == 0)
        begin
            hw[31:20] = $urandom_range(0, 1) ? 12'h7ff : 12'h800;
            hw[19:8]  = $urandom_range(0, 1) ? 12'h7ff : 12'h800;
        end
        return hw;
    endfunction

    task automatic send_group(int n_bytes);
        send_header(random_header());
        repeat (n_bytes) offer(OP_DATA, '0, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_header(logic [31:0] hw);
        offer(OP_HEADER, hw, '0);
    endtask

    initial
    begin
        logic [31:0] hw;
        int          pick;
        bit          hold_asked;
        bit          paused;
        hold_asked  = 1'b0;
        paused      = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= OP_HEADER;
        header_word <= '0;
        data_byte   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // data before any header decodes from the reset state
        offer(OP_DATA, '0, 8'h00);
        offer(OP_DATA, '0, 8'hff);
        offer(OP_DATA, '0, 8'h7f);
        offer(OP_DATA, '0, 8'h80);
        send_header(32'h0000_0000);
        send_header(32'hffff_ffff);
        offer(OP_DATA, '0, 8'h77);
        offer(OP_DATA, '0, 8'h88);
        // saturate high, then low
        send_header({12'h7ff, 12'h7ff, 3'd4, 5'd31});
        offer(OP_DATA, '0, 8'h77);
        send_header({12'h800, 12'h800, 3'd4, 5'd31});
        offer(OP_DATA, '0, 8'h88);
        foreach (sb.gain_older[c])
        begin
            if (c != 0 && c != 4 && c != 7)
            begin
                hw      = $urandom;
                hw[7:5] = 3'(c);
                send_header(hw);
                offer(OP_DATA, '0, 8'($urandom_range(0, 255)));
            end
        end
        drain();

        while (items_sent < TOTAL_ITEMS)
        begin
            gaps_on = !(items_sent >= 300 && items_sent < 450);
            if (!hold_asked && items_sent >= 600)
            begin
                want_hold  = 1'b1;
                hold_asked = 1'b1;
            end
            if (!paused && items_sent >= 800)
            begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
                send_group(32);
            else if (pick < 90)
                send_group($urandom_range(0, 31));
            else
                // stray bytes run on from stale state and may wrap the byte count
                repeat ($urandom_range(1, 40)) offer(OP_DATA, '0, 8'($urandom_range(0, 255)));
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
src/xagd_pkg.sv
src/xa_style_adpcm_group_decoder.sv
src/xagd_chk.sv
tb/sv/xa_style_adpcm_group_decoder_tb.sv
